// ----- design/pid_controller_clamped_output_unit_assert.svh -----
// assertion macros for the pid controller unit
// defines empty bodies when ASSERT_OFF is set; no other dependencies
`ifndef PID_CONTROLLER_CLAMPED_OUTPUT_UNIT_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_OUTPUT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PIDC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pidc assertion failed");
`define PIDC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pidc forbidden condition seen");
`else
`define PIDC_ASSERT(lbl, clk, rst, prop)
`define PIDC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- design/pidc_pkg.sv -----
// shared types and constants of the pid controller unit
// no dependencies
package pidc_pkg;

   localparam int GainWidth  = 16;
   localparam int InWidth    = 16;
   localparam int ErrWidth   = 17;
   localparam int ProdWidth  = 35;
   localparam int IntegWidth = 48;
   localparam int AccWidth   = 50;
   localparam int DriveWidth = 12;
   localparam int IndexWidth = 2;

   typedef enum logic [IndexWidth-1:0] {
      REG_PROP_GAIN     = 2'd0,
      REG_INTEGRAL_GAIN = 2'd1,
      REG_DERIV_GAIN    = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2,
      CLAMP_RSVD = 2'd3
   } clamp_type;

   localparam logic [GainWidth-1:0] PropGainReset     = 16'd512;
   localparam logic [GainWidth-1:0] IntegralGainReset = 16'd768;
   localparam logic [GainWidth-1:0] DerivGainReset    = 16'd512;

   // ten volts per 1.0 of the q16.16 sum, full scale is ten volts
   localparam logic signed [AccWidth-1:0] FullScaleSum = 50'sd65536;
   localparam logic [DriveWidth-1:0]      DriveFull    = 12'd2560;

endpackage

// ----- design/pid_controller_clamped_output_unit.sv -----
// pid controller unit: one shared multiplier under a small sequencer
// depends on pidc_pkg and pid_controller_clamped_output_unit_assert.svh
//
// Each accepted word (measured, target) produces one rsp word (drive, clamp_state).
// A word passes from its accepting edge through three multiply steps on the
// single 18x17 signed multiplier (proportional, integral, derivative), two
// accumulate steps and one output step, which loads its result into the output
// register once it is empty or being taken. A new word is accepted only in the idle
// state, after the last word has left the output step. req_stall stays high while
// a word is in the sequencer; the output register lets the next word start while
// the last result waits. Gains are written through csr_wr_en/csr_index/csr_wdata
// while the unit is idle, a rule on the user that the unit does not enforce;
// writes to index 3 are ignored. The integral saturates at 48 bits.
`include "pid_controller_clamped_output_unit_assert.svh"

module pid_controller_clamped_output_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pidc_pkg::IndexWidth-1:0]       csr_index,
   input  logic [pidc_pkg::GainWidth-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pidc_pkg::InWidth-1:0]   req_measured,
   input  logic signed [pidc_pkg::InWidth-1:0]   req_target,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pidc_pkg::DriveWidth-1:0]       rsp_drive,
   output logic [1:0]                            rsp_clamp_state
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MULP = 7'b0000010,
      S_MULI = 7'b0000100,
      S_MULD = 7'b0001000,
      S_ADDI = 7'b0010000,
      S_ADDD = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [pidc_pkg::GainWidth-1:0] prop_gain_ff, prop_gain_in;
   logic [pidc_pkg::GainWidth-1:0] integral_gain_ff, integral_gain_in;
   logic [pidc_pkg::GainWidth-1:0] deriv_gain_ff, deriv_gain_in;

   logic signed [pidc_pkg::ErrWidth-1:0]   err_ff, err_in;
   logic signed [pidc_pkg::ErrWidth-1:0]   prev_err_ff, prev_err_in;
   logic signed [pidc_pkg::ProdWidth-1:0]  prod_ff, prod_in;
   logic signed [pidc_pkg::IntegWidth-1:0] integ_ff, integ_in;
   logic signed [pidc_pkg::AccWidth-1:0]   acc_ff, acc_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pidc_pkg::DriveWidth-1:0] rsp_drive_ff, rsp_drive_in;
   logic [1:0]                      rsp_clamp_ff, rsp_clamp_in;

   logic signed [pidc_pkg::ErrWidth:0]     mul_a;
   logic signed [pidc_pkg::GainWidth:0]    mul_b;
   logic signed [pidc_pkg::ProdWidth-1:0]  mul_p;
   logic signed [pidc_pkg::IntegWidth:0]   integ_sum;
   logic signed [pidc_pkg::AccWidth-1:0]   acc_addend;
   logic signed [pidc_pkg::AccWidth-1:0]   acc_sum;
   logic [pidc_pkg::ErrWidth-1:0]          in_range_val;
   logic [20:0]                            times_ten;
   logic                                   req_accept;
   logic                                   out_load;
   logic                                   sum_over;
   logic                                   sum_neg;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_MULP: begin
            mul_a = (pidc_pkg::ErrWidth+1)'(err_ff);
            mul_b = {1'b0, prop_gain_ff};
         end
         S_MULI: begin
            mul_a = (pidc_pkg::ErrWidth+1)'(err_ff);
            mul_b = {1'b0, integral_gain_ff};
         end
         S_MULD: begin
            mul_a = (pidc_pkg::ErrWidth+1)'(err_ff) - (pidc_pkg::ErrWidth+1)'(prev_err_ff);
            mul_b = {1'b0, deriv_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // saturating integral update
   assign integ_sum = (pidc_pkg::IntegWidth+1)'(integ_ff)
                    + (pidc_pkg::IntegWidth+1)'(prod_ff);

   assign acc_addend = (state_ff == S_ADDI) ? pidc_pkg::AccWidth'(integ_ff)
                                            : pidc_pkg::AccWidth'(prod_ff);
   assign acc_sum    = acc_ff + acc_addend;

   // output scaling and clamp
   assign sum_neg      = acc_ff[pidc_pkg::AccWidth-1];
   assign sum_over     = !sum_neg && (acc_ff > pidc_pkg::FullScaleSum);
   assign in_range_val = acc_ff[pidc_pkg::ErrWidth-1:0];
   assign times_ten    = 21'({in_range_val, 3'b000}) + 21'({in_range_val, 1'b0});

   always_comb begin
      state_in         = state_ff;
      err_in           = err_ff;
      prev_err_in      = prev_err_ff;
      prod_in          = prod_ff;
      integ_in         = integ_ff;
      acc_in           = acc_ff;
      rsp_drive_in     = rsp_drive_ff;
      rsp_clamp_in     = rsp_clamp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      prop_gain_in     = prop_gain_ff;
      integral_gain_in = integral_gain_ff;
      deriv_gain_in    = deriv_gain_ff;

      if (csr_wr_en) begin
         case (pidc_pkg::reg_index_type'(csr_index))
            pidc_pkg::REG_PROP_GAIN:     prop_gain_in     = csr_wdata;
            pidc_pkg::REG_INTEGRAL_GAIN: integral_gain_in = csr_wdata;
            pidc_pkg::REG_DERIV_GAIN:    deriv_gain_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               err_in   = pidc_pkg::ErrWidth'(req_measured) - pidc_pkg::ErrWidth'(req_target);
               state_in = S_MULP;
            end
         end
         S_MULP: begin
            prod_in  = mul_p;
            state_in = S_MULI;
         end
         S_MULI: begin
            acc_in   = pidc_pkg::AccWidth'(prod_ff);
            prod_in  = mul_p;
            state_in = S_MULD;
         end
         S_MULD: begin
            if (integ_sum[pidc_pkg::IntegWidth] != integ_sum[pidc_pkg::IntegWidth-1]) begin
               integ_in = {integ_sum[pidc_pkg::IntegWidth],
                           {(pidc_pkg::IntegWidth-1){~integ_sum[pidc_pkg::IntegWidth]}}};
            end else begin
               integ_in = integ_sum[pidc_pkg::IntegWidth-1:0];
            end
            prod_in     = mul_p;
            prev_err_in = err_ff;
            state_in    = S_ADDI;
         end
         S_ADDI: begin
            acc_in   = acc_sum;
            state_in = S_ADDD;
         end
         S_ADDD: begin
            acc_in   = acc_sum;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (sum_over) begin
                  rsp_drive_in = pidc_pkg::DriveFull;
                  rsp_clamp_in = pidc_pkg::CLAMP_HIGH;
               end else if (sum_neg) begin
                  rsp_drive_in = '0;
                  rsp_clamp_in = pidc_pkg::CLAMP_LOW;
               end else begin
                  rsp_drive_in = times_ten[19:8];
                  rsp_clamp_in = pidc_pkg::CLAMP_NONE;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         prop_gain_ff     <= pidc_pkg::PropGainReset;
         integral_gain_ff <= pidc_pkg::IntegralGainReset;
         deriv_gain_ff    <= pidc_pkg::DerivGainReset;
         integ_ff         <= '0;
         prev_err_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         prop_gain_ff     <= prop_gain_in;
         integral_gain_ff <= integral_gain_in;
         deriv_gain_ff    <= deriv_gain_in;
         integ_ff         <= integ_in;
         prev_err_ff      <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_clamp_state = rsp_clamp_ff;

   `PIDC_ASSERT(a_accept_starts_mul, clock, reset, req_accept |=> (state_ff == S_MULP))
   `PIDC_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
   `PIDC_ASSERT(a_prev_err_step, clock, reset, !$stable(prev_err_ff) |-> $past(state_ff == S_MULD))
   `PIDC_ASSERT_NEVER(a_high_drive, clock, reset, rsp_valid_ff && (rsp_clamp_ff == pidc_pkg::CLAMP_HIGH) && (rsp_drive_ff != pidc_pkg::DriveFull))
   `PIDC_ASSERT_NEVER(a_low_drive, clock, reset, rsp_valid_ff && (rsp_clamp_ff == pidc_pkg::CLAMP_LOW) && (rsp_drive_ff != '0))

endmodule
